>>> rtl/rta_pkg.sv
package rta_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int RADIX_W = 6;
	localparam int DIGIT_W = 6;
	localparam int CHAR_W = 7;

	localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

	localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_A = 7'h41;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
	localparam logic [DIGIT_W-1:0] LAST_DEC_DIGIT = 6'd9;
	localparam logic [CHAR_W-1:0] DEC_DIGITS = 7'd10;

	typedef struct packed {
		logic clear;
		logic feed;
		logic feed_bit;
		logic shift;
	} rta_ctrl_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d > LAST_DEC_DIGIT) begin
			c = {1'b0, d} + (CHAR_A - DEC_DIGITS);
		end else begin
			c = {1'b0, d} + CHAR_ZERO;
		end
		return c;
	endfunction

endpackage

>>> rtl/int_to_radix_ascii.sv
// Operation: after an input transfer the magnitude is fed bit by bit into the cells and
// the carries ripple up until the cells go idle; leading zero digits are then shifted
// out, a minus sign is sent for a negative value, and the digits follow, most significant
// first. Output stalls hold the flow; the next input transfer waits until the last
// character of the current value has been loaded into the output register.
// Reset: arst_n clears the controller, the cell activity chain and m_tvalid.
module int_to_radix_ascii #(
	parameter int VALUE_WIDTH = rta_pkg::VALUE_WIDTH_DEF,
	localparam int S_DATA_W = ((rta_pkg::RADIX_W + VALUE_WIDTH + 7) / 8) * 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // radix[5:0], value[VALUE_WIDTH+5:6]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,  // char_code[6:0]
	output logic                m_tlast
);
	import rta_pkg::*;

	localparam int CELLS = VALUE_WIDTH + 1;
	localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
	localparam int REM_W = $clog2(CELLS + 1);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_CONV = 5'b00010,
		ST_SKIP = 5'b00100,
		ST_SIGN = 5'b01000,
		ST_DIG  = 5'b10000
	} state_t;

	state_t                 state_q;
	logic [RADIX_W-1:0]     radix_q;
	logic [VALUE_WIDTH-1:0] mag_q;
	logic                   neg_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [REM_W-1:0]       rem_q;
	logic [CHAR_W-1:0]      char_q;
	logic                   last_q;

	logic                   accept;
	logic                   out_free;
	logic                   feeding;
	logic                   lead_zero;
	logic                   busy;
	logic [DIGIT_W-1:0]     top_digit;
	logic [RADIX_W-1:0]     in_radix;
	logic [VALUE_WIDTH-1:0] in_value;
	logic [RADIX_W-1:0]     radix_clamped;
	rta_ctrl_t              ctrl;

	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;
	assign in_radix = s_tdata[RADIX_W-1:0];
	assign in_value = s_tdata[RADIX_W +: VALUE_WIDTH];
	assign feeding = (state_q == ST_CONV) && (cnt_q != CNT_W'(VALUE_WIDTH));
	assign lead_zero = (top_digit == '0) && (rem_q > REM_W'(1));

	always_comb begin
		if (in_radix < RADIX_MIN) begin
			radix_clamped = RADIX_MIN;
		end else if (in_radix > RADIX_MAX) begin
			radix_clamped = RADIX_MAX;
		end else begin
			radix_clamped = in_radix;
		end
	end

	always_comb begin
		ctrl.clear = accept;
		ctrl.feed = feeding;
		ctrl.feed_bit = mag_q[VALUE_WIDTH-1];
		ctrl.shift = ((state_q == ST_SKIP) && lead_zero) ||
		             ((state_q == ST_DIG) && out_free);
	end

	rta_chain #(
		.CELLS (CELLS)
	) u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.radix     (radix_q),
		.busy      (busy),
		.top_digit (top_digit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			rem_q <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (out_free) begin
				m_tvalid <= (state_q == ST_SIGN) || (state_q == ST_DIG);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CONV;
						cnt_q <= '0;
						rem_q <= REM_W'(CELLS);
					end
				end
				ST_CONV: begin
					if (feeding) begin
						cnt_q <= cnt_q + 1'b1;
					end else if (!busy) begin
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (lead_zero) begin
						rem_q <= rem_q - 1'b1;
					end else begin
						state_q <= neg_q ? ST_SIGN : ST_DIG;
					end
				end
				ST_SIGN: begin
					if (out_free) begin
						state_q <= ST_DIG;
					end
				end
				ST_DIG: begin
					if (out_free) begin
						rem_q <= rem_q - 1'b1;
						if (rem_q == REM_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			radix_q <= radix_clamped;
			neg_q <= in_value[VALUE_WIDTH-1];
			mag_q <= in_value[VALUE_WIDTH-1] ? (~in_value + 1'b1) : in_value;
		end else if (feeding) begin
			mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
		end
		if ((state_q == ST_SIGN) && out_free) begin
			char_q <= CHAR_MINUS;
			last_q <= 1'b0;
		end else if ((state_q == ST_DIG) && out_free) begin
			char_q <= digit_char(top_digit);
			last_q <= (rem_q == REM_W'(1));
		end
	end

	assign m_tdata = {1'b0, char_q};
	assign m_tlast = last_q;

`ifndef SYNTHESIS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_CONV) && (cnt_q == '0))
		else $error("accepted item did not start conversion");
	a_dig_remaining: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIG) |-> (rem_q != '0))
		else $error("digit emission with no digits left");
	a_radix_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONV) |-> (radix_q >= RADIX_MIN) && (radix_q <= RADIX_MAX))
		else $error("radix outside the supported range");
`endif

endmodule

>>> rtl/rta_cell.sv
module rta_cell (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rta_pkg::rta_ctrl_t              ctrl,
	input  logic [rta_pkg::RADIX_W-1:0]     radix,
	input  logic                            act_in,
	input  logic                            carry_in,
	input  logic [rta_pkg::DIGIT_W-1:0]     digit_in,
	output logic                            act_q,
	output logic                            carry_q,
	output logic [rta_pkg::DIGIT_W-1:0]     digit_q
);
	import rta_pkg::*;

	logic [DIGIT_W:0]   sum;
	logic [DIGIT_W-1:0] diff;
	logic               wrap;

	// Each active cycle doubles the digit and adds the carry from below.
	always_comb begin
		sum = {digit_q, carry_in};
		diff = sum[DIGIT_W-1:0] - radix;
		wrap = sum >= {1'b0, radix};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else begin
			act_q <= ctrl.clear ? 1'b0 : act_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			digit_q <= '0;
			carry_q <= 1'b0;
		end else if (ctrl.shift) begin
			digit_q <= digit_in;
			carry_q <= 1'b0;
		end else if (act_in) begin
			digit_q <= wrap ? diff : sum[DIGIT_W-1:0];
			carry_q <= wrap;
		end
	end

endmodule

>>> rtl/rta_chain.sv
module rta_chain #(
	parameter int CELLS = rta_pkg::VALUE_WIDTH_DEF + 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rta_pkg::rta_ctrl_t              ctrl,
	input  logic [rta_pkg::RADIX_W-1:0]     radix,
	output logic                            busy,
	output logic [rta_pkg::DIGIT_W-1:0]     top_digit
);
	import rta_pkg::*;

	logic [CELLS-1:0]   act;
	logic [CELLS-1:0]   carry;
	logic [DIGIT_W-1:0] digit [CELLS];

	// Cell zero holds the least significant digit; shifting moves digits upward.
	for (genvar k = 0; k < CELLS; k++) begin : g_cell
		if (k == 0) begin : g_first
			rta_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl),
				.radix    (radix),
				.act_in   (ctrl.feed),
				.carry_in (ctrl.feed_bit),
				.digit_in ('0),
				.act_q    (act[k]),
				.carry_q  (carry[k]),
				.digit_q  (digit[k])
			);
		end else begin : g_next
			rta_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl),
				.radix    (radix),
				.act_in   (act[k-1]),
				.carry_in (carry[k-1]),
				.digit_in (digit[k-1]),
				.act_q    (act[k]),
				.carry_q  (carry[k]),
				.digit_q  (digit[k])
			);
		end
	end

	assign busy = |act;
	assign top_digit = digit[CELLS-1];

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		act[CELLS-1] |-> !carry[CELLS-1])
		else $error("carry left the top digit cell");
	a_feed_idle_shift: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.shift |-> !busy && !ctrl.feed)
		else $error("digit shift while conversion still in flight");
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.shift |-> top_digit < radix)
		else $error("top digit out of radix range");
`endif

endmodule

>>> bench/int_to_radix_ascii_tb.sv
module int_to_radix_ascii_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rta_pkg::*;

	localparam int VALUE_W = VALUE_WIDTH_DEF;
	localparam int S_DATA_W = ((RADIX_W + VALUE_W + 7) / 8) * 8;
	localparam int PHASE_ITEMS = 129;
	localparam int TAIL_CYCLES = 200;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic [RADIX_W-1:0] radix;
		logic [VALUE_W-1:0] value;
	} number_req_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic              is_last;
	} text_char_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [7:0]          m_tdata;
	logic                m_tlast;

	number_req_t pending_numbers[$];
	text_char_t  expected_chars[$];
	int          numbers_queued = 0;
	int          numbers_accepted = 0;
	int          sender_idle_pct = 0;
	int          receiver_stall_pct = 0;
	int          cycle_count = 0;
	bit          failed = 1'b0;

	int_to_radix_ascii uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Appends the characters of one number, most significant first, to the expected text.
	function automatic void spell_number(input logic [RADIX_W-1:0] radix_in,
			input logic [VALUE_W-1:0] value_in);
		logic [RADIX_W-1:0] base;
		logic [VALUE_W-1:0] magnitude;
		logic [DIGIT_W-1:0] digits [0:VALUE_W];
		int                 count;
		text_char_t         c;
		base = (radix_in < RADIX_MIN) ? RADIX_MIN : (radix_in > RADIX_MAX) ? RADIX_MAX : radix_in;
		magnitude = value_in[VALUE_W-1] ? (~value_in + 1'b1) : value_in;
		count = 0;
		do begin
			digits[count] = DIGIT_W'(magnitude % base);
			count++;
			magnitude = magnitude / base;
		end while (magnitude != 0);
		if (value_in[VALUE_W-1]) begin
			c.char_code = CHAR_MINUS;
			c.is_last = 1'b0;
			expected_chars.push_back(c);
		end
		for (int k = count - 1; k >= 0; k--) begin
			if (digits[k] > LAST_DEC_DIGIT) begin
				c.char_code = CHAR_A + CHAR_W'(digits[k]) - CHAR_W'(LAST_DEC_DIGIT + 1'b1);
			end else begin
				c.char_code = CHAR_ZERO + CHAR_W'(digits[k]);
			end
			c.is_last = (k == 0);
			expected_chars.push_back(c);
		end
	endfunction

	function automatic logic [VALUE_W-1:0] random_value(input logic [RADIX_W-1:0] radix_in);
		logic [VALUE_W-1:0] v;
		logic [VALUE_W-1:0] p;
		int                 base;
		base = (radix_in < RADIX_MIN) ? RADIX_MIN : (radix_in > RADIX_MAX) ? RADIX_MAX : radix_in;
		case ($urandom_range(9))
			0, 1, 2, 3: v = $urandom;
			4, 5: v = VALUE_W'($urandom_range(600)) - VALUE_W'(300);
			6, 7: begin
				v = $urandom >> $urandom_range(31);
				if ($urandom_range(1)) begin
					v = -v;
				end
			end
			8: begin
				case ($urandom_range(3))
					0: v = {1'b1, {(VALUE_W-1){1'b0}}};
					1: v = {1'b0, {(VALUE_W-1){1'b1}}};
					2: v = '0;
					default: v = '1;
				endcase
			end
			default: begin
				p = 1;
				repeat ($urandom_range(1, 31)) begin
					if (p <= VALUE_W'(32'h7FFF_FFFF) / VALUE_W'(base)) begin
						p = p * VALUE_W'(base);
					end
				end
				v = p + VALUE_W'($urandom_range(2)) - 1'b1;
				if ($urandom_range(1)) begin
					v = -v;
				end
			end
		endcase
		return v;
	endfunction

	task automatic queue_number(input logic [RADIX_W-1:0] radix_in,
			input logic [VALUE_W-1:0] value_in);
		number_req_t req;
		req.radix = radix_in;
		req.value = value_in;
		pending_numbers.push_back(req);
		numbers_queued++;
	endtask

	task automatic wait_for_drain();
		do begin
			@(negedge clk);
		end while (numbers_accepted != numbers_queued || expected_chars.size() != 0);
	endtask

	task automatic run_random_phase(input int idle_pct, input int stall_pct);
		logic [RADIX_W-1:0] r;
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		repeat (PHASE_ITEMS) begin
			if ($urandom_range(99) < 15) begin
				r = $urandom_range(63);
			end else begin
				r = $urandom_range(2, 36);
			end
			queue_number(r, random_value(r));
		end
		wait_for_drain();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		sender_idle_pct = 25;
		receiver_stall_pct = 74;
		queue_number(6'd10, 32'd0);
		queue_number(6'd2, 32'd0);
		queue_number(6'd10, 32'd1);
		queue_number(6'd10, -32'sd1);
		queue_number(6'd2, 32'h8000_0000);
		queue_number(6'd2, 32'h7FFF_FFFF);
		queue_number(6'd36, 32'h8000_0000);
		queue_number(6'd36, 32'h7FFF_FFFF);
		queue_number(6'd16, -32'sd1);
		queue_number(6'd16, 32'h7FFF_FFFF);
		queue_number(6'd10, 32'h8000_0000);
		queue_number(6'd10, 32'h7FFF_FFFF);
		queue_number(6'd0, 32'd5);
		queue_number(6'd1, -32'sd7);
		queue_number(6'd37, 32'd35);
		queue_number(6'd63, -32'sd36);
		queue_number(6'd63, 32'h8000_0000);
		queue_number(6'd36, 32'd35);
		queue_number(6'd36, -32'sd36);
		queue_number(6'd11, 32'd10);
		queue_number(6'd8, 32'h8000_0000);
		queue_number(6'd3, 32'h7FFF_FFFF);
		queue_number(6'd7, 32'd123456789);
		queue_number(6'd42, 32'hAAAA_5555);
		wait_for_drain();

		run_random_phase(25, 74);
		run_random_phase(74, 25);
		run_random_phase(0, 0);

		repeat (TAIL_CYCLES) @(posedge clk);
		if (!failed) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		number_req_t req;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (pending_numbers.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				req = pending_numbers.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= S_DATA_W'({req.value, req.radix});
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Input transfers are predicted before output transfers are checked in the same cycle.
	always @(posedge clk or negedge arst_n) begin
		text_char_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				spell_number(s_tdata[RADIX_W-1:0], s_tdata[RADIX_W +: VALUE_W]);
				numbers_accepted++;
			end
			if (m_tvalid && m_tready) begin
				if (expected_chars.size() == 0) begin
					$display("%0t: unexpected character transfer %h last %b",
						$time, m_tdata, m_tlast);
					failed = 1'b1;
				end else begin
					want = expected_chars.pop_front();
					if (m_tdata !== {1'b0, want.char_code}) begin
						$display("%0t: char_code mismatch, expected %h actual %h",
							$time, {1'b0, want.char_code}, m_tdata);
						failed = 1'b1;
					end
					if (m_tlast !== want.is_last) begin
						$display("%0t: is_last mismatch, expected %b actual %b",
							$time, want.is_last, m_tlast);
						failed = 1'b1;
					end
				end
			end
			m_tready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

endmodule
